/* design/wast_pkg.sv */
// ----------------------------------------------------------------------------
// wast_pkg - shared types and constants of the weekly alarm slot table
// Slot record layout, command and status codes, sequencer states and the
// repeat-mode table used by the add command.
// ----------------------------------------------------------------------------
package wast_pkg;

    // number of alarm slots and the index width that follows from it
    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // clamp limits and mask defaults
    localparam logic [4:0] HOUR_MAX    = 5'd23;
    localparam logic [5:0] MINUTE_MAX  = 6'd59;
    localparam logic [6:0] DAYS_ALL    = 7'h7F;
    localparam logic [6:0] DAYS_WORK   = 7'h3E;
    localparam logic [6:0] DAYS_WEEKND = 7'h41;

    // command codes
    typedef enum logic [2:0] {
        CMD_CHECK  = 3'd0,
        CMD_SET    = 3'd1,
        CMD_GET    = 3'd2,
        CMD_ADD    = 3'd3,
        CMD_TOGGLE = 3'd4,
        CMD_DELETE = 3'd5
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_DONE   = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_SAME   = 2'd2,
        STAT_NOTIME = 2'd3
    } status_t;

    // add repeat modes
    typedef enum logic [1:0] {
        MODE_DAILY   = 2'd0,
        MODE_WORK    = 2'd1,
        MODE_WEEKEND = 2'd2,
        MODE_ONCE    = 2'd3
    } mode_t;

    // sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_SCAN = 2'd1,
        SEQ_EXEC = 2'd2
    } seq_state_t;

    // one alarm slot
    typedef struct packed {
        logic        en;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [6:0]  days;
        logic        once;
        logic [31:0] lastday;
    } entry_t;

    // one result word
    typedef struct packed {
        logic       fired;
        logic [3:0] fired_slot;
        logic [1:0] status;
        logic       read_enable;
        logic [4:0] read_hour;
        logic [5:0] read_minute;
        logic [6:0] read_weekdays;
        logic       read_one_shot;
        logic       save_needed;
    } rsp_t;

    // weekday mask for an add mode
    function automatic logic [6:0] mode_days(input logic [1:0] mode);
        logic [6:0] d;
        case (mode)
            MODE_DAILY:   d = DAYS_ALL;
            MODE_WORK:    d = DAYS_WORK;
            MODE_WEEKEND: d = DAYS_WEEKND;
            MODE_ONCE:    d = DAYS_ALL;
            default:      d = DAYS_ALL;
        endcase
        return d;
    endfunction

endpackage

/* design/wast_req_if.sv */
// ----------------------------------------------------------------------------
// wast_req_if - command channel of the weekly alarm slot table
// Valid/ready channel carrying one command word per transfer.
// ----------------------------------------------------------------------------
interface wast_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  slot;
    logic [7:0]  enable_in;
    logic [7:0]  hour_in;
    logic [7:0]  minute_in;
    logic [7:0]  weekday_mask_in;
    logic [7:0]  one_shot_in;
    logic [1:0]  repeat_mode;
    logic [2:0]  weekday_now;
    logic [31:0] day_number;
    logic        time_valid;

    modport source (
        output valid, cmd, slot, enable_in, hour_in, minute_in, weekday_mask_in,
               one_shot_in, repeat_mode, weekday_now, day_number, time_valid,
        input  ready
    );

    modport sink (
        input  valid, cmd, slot, enable_in, hour_in, minute_in, weekday_mask_in,
               one_shot_in, repeat_mode, weekday_now, day_number, time_valid,
        output ready
    );
endinterface

/* design/wast_rsp_if.sv */
// ----------------------------------------------------------------------------
// wast_rsp_if - result channel of the weekly alarm slot table
// Valid/ready channel carrying one result word per transfer.
// ----------------------------------------------------------------------------
interface wast_rsp_if;
    logic       valid;
    logic       ready;
    logic       fired;
    logic [3:0] fired_slot;
    logic [1:0] status;
    logic       read_enable;
    logic [4:0] read_hour;
    logic [5:0] read_minute;
    logic [6:0] read_weekdays;
    logic       read_one_shot;
    logic       save_needed;

    modport source (
        output valid, fired, fired_slot, status, read_enable, read_hour,
               read_minute, read_weekdays, read_one_shot, save_needed,
        input  ready
    );

    modport sink (
        input  valid, fired, fired_slot, status, read_enable, read_hour,
               read_minute, read_weekdays, read_one_shot, save_needed,
        output ready
    );
endinterface

/* design/weekly_alarm_slot_table.sv */
// ----------------------------------------------------------------------------
// weekly_alarm_slot_table - alarm slot table with check/set/get/add/toggle/delete
// Sixteen alarm slots in registers, one slot examined per cycle by a
// small sequencer; every command word gives exactly one result word.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word per valid/ready transfer; rsp returns one
//   result word per command, in order. req.ready is high only while the
//   sequencer is idle, so one command is worked on at a time.
// Sequencing:
//   check (with valid time) and add scan the slots from index 0, one slot per
//   cycle through a single compare unit, and stop at the first hit. The other
//   commands, and check without valid time, go straight from idle to the
//   execute state. A new command is taken only after the previous one has
//   written its result register.
// Reset:
//   rst_n clears every slot field to zero at once; no clearing pass, the
//   block is ready for a command straight out of reset.
// Stalls:
//   the result sits in an output register; while it waits the next command
//   is still accepted and worked on, and only its final write step holds
//   until the output register is free.
// ----------------------------------------------------------------------------
module weekly_alarm_slot_table (
    input  logic         clk,
    input  logic         rst_n,
    wast_req_if.sink     req,
    wast_rsp_if.source   rsp
);

    // state and command registers
    wast_pkg::seq_state_t          state_reg, state_next;
    logic [wast_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic                          found_reg, found_next;
    logic [2:0]                    cmd_reg;
    logic [7:0]                    slot_reg;
    logic [7:0]                    enable_reg;
    logic [7:0]                    hour_reg;
    logic [7:0]                    minute_reg;
    logic [7:0]                    mask_reg;
    logic [7:0]                    once_reg;
    logic [1:0]                    mode_reg;
    logic [2:0]                    wday_reg;
    logic [31:0]                   day_reg;
    logic                          tvalid_reg;

    // slot table and output register
    wast_pkg::entry_t              table_reg [wast_pkg::SLOTS];
    wast_pkg::rsp_t                rsp_reg, rsp_next;
    logic                          rsp_valid_reg;

    // datapath signals
    wast_pkg::entry_t              cur;
    wast_pkg::entry_t              wr_data;
    logic                          wr_en;
    logic [7:0]                    days_ext;
    logic                          match;
    logic                          hit;
    logic                          accept;
    logic                          exec_go;
    logic                          slot_bad;
    logic [4:0]                    hour_clamp;
    logic [5:0]                    minute_clamp;
    logic [6:0]                    mask_set;
    logic                          en_set;
    logic                          once_set;

    // handshake
    assign req.ready = (state_reg == wast_pkg::SEQ_IDLE);
    assign accept    = req.valid && req.ready;
    assign exec_go   = (state_reg == wast_pkg::SEQ_EXEC) && (!rsp_valid_reg || rsp.ready);

    // shared slot read and compare unit
    assign cur      = table_reg[idx_reg];
    assign days_ext = {1'b0, cur.days};
    assign match    = cur.en && days_ext[wday_reg] &&
                      ({3'b000, cur.hour} == hour_reg) &&
                      ({2'b00, cur.minute} == minute_reg) &&
                      (cur.lastday != day_reg);
    assign hit      = (cmd_reg == wast_pkg::CMD_CHECK) ? match : !cur.en;

    // clamped / normalized write values
    assign hour_clamp   = (hour_reg > {3'b000, wast_pkg::HOUR_MAX}) ?
                          wast_pkg::HOUR_MAX : hour_reg[4:0];
    assign minute_clamp = (minute_reg > {2'b00, wast_pkg::MINUTE_MAX}) ?
                          wast_pkg::MINUTE_MAX : minute_reg[5:0];
    assign mask_set     = (mask_reg[6:0] == 7'd0) ? wast_pkg::DAYS_ALL : mask_reg[6:0];
    assign en_set       = (enable_reg != 8'd0);
    assign once_set     = (once_reg != 8'd0);
    assign slot_bad     = (slot_reg >= 8'(wast_pkg::SLOTS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        case (state_reg)
            wast_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    found_next = 1'b0;
                    if ((req.cmd == wast_pkg::CMD_CHECK && req.time_valid) ||
                        req.cmd == wast_pkg::CMD_ADD)
                    begin
                        idx_next   = '0;
                        state_next = wast_pkg::SEQ_SCAN;
                    end
                    else
                    begin
                        idx_next   = req.slot[wast_pkg::IDX_W-1:0];
                        state_next = wast_pkg::SEQ_EXEC;
                    end
                end
            end
            wast_pkg::SEQ_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    state_next = wast_pkg::SEQ_EXEC;
                end
                else if (idx_reg == wast_pkg::IDX_W'(wast_pkg::SLOTS - 1))
                begin
                    // nothing found: add falls back to slot 0
                    idx_next   = '0;
                    state_next = wast_pkg::SEQ_EXEC;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            wast_pkg::SEQ_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = wast_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = wast_pkg::SEQ_IDLE;
            end
        endcase
    end

    // command execution: table write and result word
    always_comb
    begin
        wr_en    = 1'b0;
        wr_data  = cur;
        rsp_next = '0;
        case (cmd_reg)
            wast_pkg::CMD_CHECK:
            begin
                if (!tvalid_reg)
                begin
                    rsp_next.status = wast_pkg::STAT_NOTIME;
                end
                else
                begin
                    rsp_next.status = wast_pkg::STAT_DONE;
                    if (found_reg)
                    begin
                        wr_en               = 1'b1;
                        wr_data.lastday     = day_reg;
                        wr_data.en          = cur.en && !cur.once;
                        rsp_next.fired      = 1'b1;
                        rsp_next.fired_slot = 4'(idx_reg);
                        rsp_next.save_needed = 1'b1;
                    end
                end
            end
            wast_pkg::CMD_ADD:
            begin
                wr_en                = 1'b1;
                wr_data.en           = 1'b1;
                wr_data.hour         = hour_clamp;
                wr_data.minute       = minute_clamp;
                wr_data.days         = wast_pkg::mode_days(mode_reg);
                wr_data.once         = (mode_reg == wast_pkg::MODE_ONCE);
                wr_data.lastday      = '0;
                rsp_next.fired_slot  = 4'(idx_reg);
                rsp_next.status      = wast_pkg::STAT_DONE;
                rsp_next.save_needed = 1'b1;
            end
            wast_pkg::CMD_SET:
            begin
                if (slot_bad)
                begin
                    rsp_next.status = wast_pkg::STAT_RANGE;
                end
                else if (cur.en == en_set && cur.hour == hour_clamp &&
                         cur.minute == minute_clamp && cur.days == mask_set &&
                         cur.once == once_set)
                begin
                    rsp_next.status = wast_pkg::STAT_SAME;
                end
                else
                begin
                    wr_en                = 1'b1;
                    wr_data.en           = en_set;
                    wr_data.hour         = hour_clamp;
                    wr_data.minute       = minute_clamp;
                    wr_data.days         = mask_set;
                    wr_data.once         = once_set;
                    wr_data.lastday      = '0;
                    rsp_next.status      = wast_pkg::STAT_DONE;
                    rsp_next.save_needed = 1'b1;
                end
            end
            wast_pkg::CMD_GET:
            begin
                if (slot_bad)
                begin
                    rsp_next.status = wast_pkg::STAT_RANGE;
                end
                else
                begin
                    rsp_next.status        = wast_pkg::STAT_DONE;
                    rsp_next.read_enable   = cur.en;
                    rsp_next.read_hour     = cur.hour;
                    rsp_next.read_minute   = cur.minute;
                    rsp_next.read_weekdays = cur.days;
                    rsp_next.read_one_shot = cur.once;
                end
            end
            wast_pkg::CMD_TOGGLE:
            begin
                if (slot_bad || cur.days == 7'd0)
                begin
                    rsp_next.status = wast_pkg::STAT_RANGE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data.en = !cur.en;
                    // re-enabled slot may fire again today
                    if (!cur.en)
                    begin
                        wr_data.lastday = '0;
                    end
                    rsp_next.status      = wast_pkg::STAT_DONE;
                    rsp_next.save_needed = 1'b1;
                end
            end
            wast_pkg::CMD_DELETE:
            begin
                if (slot_bad)
                begin
                    rsp_next.status = wast_pkg::STAT_RANGE;
                end
                else if (cur.days == 7'd0)
                begin
                    rsp_next.status = wast_pkg::STAT_SAME;
                end
                else
                begin
                    wr_en                = 1'b1;
                    wr_data              = '0;
                    rsp_next.status      = wast_pkg::STAT_DONE;
                    rsp_next.save_needed = 1'b1;
                end
            end
            default:
            begin
                // unused command codes: all-zero result
                rsp_next = '0;
            end
        endcase
    end

    // sequencer control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wast_pkg::SEQ_IDLE;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            if (exec_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // command capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req.cmd;
            slot_reg   <= req.slot;
            enable_reg <= req.enable_in;
            hour_reg   <= req.hour_in;
            minute_reg <= req.minute_in;
            mask_reg   <= req.weekday_mask_in;
            once_reg   <= req.one_shot_in;
            mode_reg   <= req.repeat_mode;
            wday_reg   <= req.weekday_now;
            day_reg    <= req.day_number;
            tvalid_reg <= req.time_valid;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // slot table, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wast_pkg::SLOTS; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (exec_go && wr_en)
        begin
            table_reg[idx_reg] <= wr_data;
        end
    end

    // result port
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.fired         = rsp_reg.fired;
    assign rsp.fired_slot    = rsp_reg.fired_slot;
    assign rsp.status        = rsp_reg.status;
    assign rsp.read_enable   = rsp_reg.read_enable;
    assign rsp.read_hour     = rsp_reg.read_hour;
    assign rsp.read_minute   = rsp_reg.read_minute;
    assign rsp.read_weekdays = rsp_reg.read_weekdays;
    assign rsp.read_one_shot = rsp_reg.read_one_shot;
    assign rsp.save_needed   = rsp_reg.save_needed;

endmodule

/* sim/weekly_alarm_slot_table_test.sv */
// ----------------------------------------------------------------------------
// weekly_alarm_slot_table_test - command/result check of the alarm slot table
// Drives check, set, get, add, toggle, delete and spare command words through
// the request channel with random gaps and result stalls. A shadow copy of the
// slot table predicts every result word, and each one is compared field by field.
// ----------------------------------------------------------------------------
module weekly_alarm_slot_table_test;
    import wast_pkg::*;

    // spare command codes, no effect in the block
    localparam logic [2:0] CMD_UNUSED_A = 3'd6;
    localparam logic [2:0] CMD_UNUSED_B = 3'd7;

    localparam int N_ITEMS     = 1300;
    localparam int SETTLE      = 2 * (SLOTS + 2);
    localparam int CYCLE_LIMIT = 500000;

    // one command word as it goes onto the request channel
    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  slot;
        logic [7:0]  enable_in;
        logic [7:0]  hour_in;
        logic [7:0]  minute_in;
        logic [7:0]  weekday_mask_in;
        logic [7:0]  one_shot_in;
        logic [1:0]  repeat_mode;
        logic [2:0]  weekday_now;
        logic [31:0] day_number;
        logic        time_valid;
        logic        drain_first;
    } alarm_cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    wast_req_if req_ch();
    wast_rsp_if rsp_ch();

    weekly_alarm_slot_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    // shadow slot table and queues
    entry_t     slot_shadow [SLOTS];
    alarm_cmd_t cmd_backlog [$];
    rsp_t       pending_results [$];
    alarm_cmd_t cmd_on_bus;
    alarm_cmd_t next_cmd;
    logic       hold_next;

    int words_issued  = 0;
    int words_taken   = 0;
    int results_seen  = 0;
    int results_paced = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int send_wait     = 0;
    int recv_wait     = 0;
    logic word_out    = 1'b0;
    logic send_calm   = 1'b0;
    logic recv_calm   = 1'b0;

    // --------------------------------------------------------------------
    // predictor: applies one command to the shadow table, returns its result
    // --------------------------------------------------------------------
    function automatic rsp_t apply_alarm_cmd(input alarm_cmd_t w);
        rsp_t       r;
        entry_t     e;
        logic [4:0] hh;
        logic [5:0] mm;
        logic [6:0] dm;
        logic [7:0] days8;
        logic       en_b;
        logic       once_b;
        int         idx;
        int         hit;
        r = '0;
        hh = (w.hour_in > 8'd23) ? HOUR_MAX : w.hour_in[4:0];
        mm = (w.minute_in > 8'd59) ? MINUTE_MAX : w.minute_in[5:0];
        case (w.cmd)
            CMD_CHECK:
            begin
                if (!w.time_valid)
                    r.status = STAT_NOTIME;
                else
                begin
                    // lowest enabled slot due now and not yet fired today
                    r.status = STAT_DONE;
                    hit = -1;
                    for (idx = 0; idx < SLOTS; idx++)
                    begin
                        e = slot_shadow[idx];
                        days8 = {1'b0, e.days};
                        if (hit < 0 && e.en && days8[w.weekday_now] &&
                            e.hour == w.hour_in && e.minute == w.minute_in &&
                            e.lastday != w.day_number)
                            hit = idx;
                    end
                    if (hit >= 0)
                    begin
                        slot_shadow[hit].lastday = w.day_number;
                        if (slot_shadow[hit].once)
                            slot_shadow[hit].en = 1'b0;
                        r.fired = 1'b1;
                        r.fired_slot = 4'(hit);
                        r.save_needed = 1'b1;
                    end
                end
            end
            CMD_ADD:
            begin
                // first disabled slot, slot 0 when the table is full
                hit = 0;
                for (idx = SLOTS - 1; idx >= 0; idx--)
                    if (!slot_shadow[idx].en)
                        hit = idx;
                e = '0;
                e.en = 1'b1;
                e.hour = hh;
                e.minute = mm;
                e.once = (w.repeat_mode == MODE_ONCE);
                case (w.repeat_mode)
                    MODE_WORK:    e.days = DAYS_WORK;
                    MODE_WEEKEND: e.days = DAYS_WEEKND;
                    default:      e.days = DAYS_ALL;
                endcase
                slot_shadow[hit] = e;
                r.fired_slot = 4'(hit);
                r.status = STAT_DONE;
                r.save_needed = 1'b1;
            end
            CMD_SET, CMD_GET, CMD_TOGGLE, CMD_DELETE:
            begin
                if (w.slot >= SLOTS)
                    r.status = STAT_RANGE;
                else
                begin
                    e = slot_shadow[w.slot[IDX_W-1:0]];
                    r.status = STAT_DONE;
                    case (w.cmd)
                        CMD_SET:
                        begin
                            en_b = |w.enable_in;
                            once_b = |w.one_shot_in;
                            dm = w.weekday_mask_in[6:0];
                            if (dm == 7'd0)
                                dm = DAYS_ALL;
                            if (e.en == en_b && e.hour == hh && e.minute == mm &&
                                e.days == dm && e.once == once_b)
                                r.status = STAT_SAME;
                            else
                            begin
                                e.en = en_b;
                                e.hour = hh;
                                e.minute = mm;
                                e.days = dm;
                                e.once = once_b;
                                e.lastday = '0;
                                r.save_needed = 1'b1;
                            end
                        end
                        CMD_GET:
                        begin
                            r.read_enable = e.en;
                            r.read_hour = e.hour;
                            r.read_minute = e.minute;
                            r.read_weekdays = e.days;
                            r.read_one_shot = e.once;
                        end
                        CMD_TOGGLE:
                        begin
                            // a never-written slot has an empty mask
                            if (e.days == 7'd0)
                                r.status = STAT_RANGE;
                            else
                            begin
                                e.en = ~e.en;
                                if (e.en)
                                    e.lastday = '0;
                                r.save_needed = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (e.days == 7'd0)
                                r.status = STAT_SAME;
                            else
                            begin
                                e = '0;
                                r.save_needed = 1'b1;
                            end
                        end
                    endcase
                    slot_shadow[w.slot[IDX_W-1:0]] = e;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // --------------------------------------------------------------------
    // stimulus helpers
    // --------------------------------------------------------------------
    function automatic alarm_cmd_t plain_cmd(input logic [2:0] c, input logic [7:0] s);
        alarm_cmd_t w;
        w = '0;
        w.cmd = c;
        w.slot = s;
        w.time_valid = 1'b1;
        return w;
    endfunction

    function automatic alarm_cmd_t set_cmd(input logic [7:0] s, input logic [7:0] en,
                                           input logic [7:0] hh, input logic [7:0] mm,
                                           input logic [7:0] mask, input logic [7:0] once);
        alarm_cmd_t w;
        w = plain_cmd(CMD_SET, s);
        w.enable_in = en;
        w.hour_in = hh;
        w.minute_in = mm;
        w.weekday_mask_in = mask;
        w.one_shot_in = once;
        return w;
    endfunction

    function automatic alarm_cmd_t check_cmd(input logic [7:0] hh, input logic [7:0] mm,
                                             input logic [2:0] wd, input logic [31:0] day,
                                             input logic tv);
        alarm_cmd_t w;
        w = plain_cmd(CMD_CHECK, 8'd0);
        w.hour_in = hh;
        w.minute_in = mm;
        w.weekday_now = wd;
        w.day_number = day;
        w.time_valid = tv;
        return w;
    endfunction

    function automatic alarm_cmd_t add_cmd(input logic [7:0] hh, input logic [7:0] mm,
                                           input logic [1:0] mode);
        alarm_cmd_t w;
        w = plain_cmd(CMD_ADD, 8'd0);
        w.hour_in = hh;
        w.minute_in = mm;
        w.repeat_mode = mode;
        return w;
    endfunction

    // every field drawn over its full width
    function automatic alarm_cmd_t rand_word();
        alarm_cmd_t w;
        w = '0;
        w.cmd = 3'($urandom_range(0, 7));
        w.slot = 8'($urandom());
        w.enable_in = 8'($urandom());
        w.hour_in = 8'($urandom());
        w.minute_in = 8'($urandom());
        w.weekday_mask_in = 8'($urandom());
        w.one_shot_in = 8'($urandom());
        w.repeat_mode = 2'($urandom());
        w.weekday_now = 3'($urandom());
        w.day_number = $urandom();
        w.time_valid = 1'($urandom());
        return w;
    endfunction

    // times from a small set so that checks meet the slots that were written
    function automatic logic [7:0] pick_hour();
        case ($urandom_range(0, 7))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'd23;
            default: return 8'($urandom_range(0, 2));
        endcase
    endfunction

    function automatic logic [7:0] pick_minute();
        case ($urandom_range(0, 7))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'd59;
            default: return 8'($urandom_range(0, 2));
        endcase
    endfunction

    function automatic alarm_cmd_t tame_word(input logic [2:0] c, input logic [31:0] day);
        alarm_cmd_t w;
        w = '0;
        w.cmd = c;
        w.slot = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(16, 255))
                                              : 8'($urandom_range(0, SLOTS - 1));
        w.enable_in = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        w.hour_in = pick_hour();
        w.minute_in = pick_minute();
        w.weekday_mask_in = 8'($urandom());
        w.one_shot_in = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        w.repeat_mode = 2'($urandom());
        w.weekday_now = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        w.day_number = day;
        w.time_valid = ($urandom_range(0, 15) != 0);
        return w;
    endfunction

    task automatic push_cmd(input alarm_cmd_t w);
        w.drain_first = hold_next;
        hold_next = 1'b0;
        cmd_backlog.push_back(w);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            mismatches++;
        end
    endtask

    // --------------------------------------------------------------------
    // request driver: changes at the falling edge
    // --------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (word_out && words_taken == words_issued)
                word_out = 1'b0;
            if (!word_out)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    req_ch.valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].drain_first && pending_results.size() != 0))
                begin
                    next_cmd = cmd_backlog.pop_front();
                    cmd_on_bus = next_cmd;
                    req_ch.cmd <= next_cmd.cmd;
                    req_ch.slot <= next_cmd.slot;
                    req_ch.enable_in <= next_cmd.enable_in;
                    req_ch.hour_in <= next_cmd.hour_in;
                    req_ch.minute_in <= next_cmd.minute_in;
                    req_ch.weekday_mask_in <= next_cmd.weekday_mask_in;
                    req_ch.one_shot_in <= next_cmd.one_shot_in;
                    req_ch.repeat_mode <= next_cmd.repeat_mode;
                    req_ch.weekday_now <= next_cmd.weekday_now;
                    req_ch.day_number <= next_cmd.day_number;
                    req_ch.time_valid <= next_cmd.time_valid;
                    req_ch.valid <= 1'b1;
                    words_issued++;
                    word_out = 1'b1;
                    // gap before the next word, with runs of back-to-back words
                    if ($urandom_range(0, 39) == 0)
                        send_calm = ~send_calm;
                    send_wait = send_calm ? 0 : $urandom_range(0, 19);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // accepted word: predict its result
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            pending_results.push_back(apply_alarm_cmd(cmd_on_bus));
            words_taken++;
        end
    end

    // --------------------------------------------------------------------
    // result sink: ready changes at the falling edge
    // --------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (results_seen != results_paced)
            begin
                results_paced = results_seen;
                if ($urandom_range(0, 39) == 0)
                    recv_calm = ~recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 19);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin : watch_results
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with none expected, actual status %0h slot %0h",
                         $time, rsp_ch.status, rsp_ch.fired_slot);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("fired", want.fired, rsp_ch.fired);
                compare_field("fired_slot", want.fired_slot, rsp_ch.fired_slot);
                compare_field("status", want.status, rsp_ch.status);
                compare_field("read_enable", want.read_enable, rsp_ch.read_enable);
                compare_field("read_hour", want.read_hour, rsp_ch.read_hour);
                compare_field("read_minute", want.read_minute, rsp_ch.read_minute);
                compare_field("read_weekdays", want.read_weekdays, rsp_ch.read_weekdays);
                compare_field("read_one_shot", want.read_one_shot, rsp_ch.read_one_shot);
                compare_field("save_needed", want.save_needed, rsp_ch.save_needed);
            end
            results_seen++;
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("weekly_alarm_slot_table test failed");
            $finish;
        end
    end

    // --------------------------------------------------------------------
    // stimulus, reset and end of run
    // --------------------------------------------------------------------
    initial
    begin
        alarm_cmd_t  w;
        logic [31:0] cur_day;
        int          kind;
        int          total_words;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = '0;
        req_ch.slot = '0;
        req_ch.enable_in = '0;
        req_ch.hour_in = '0;
        req_ch.minute_in = '0;
        req_ch.weekday_mask_in = '0;
        req_ch.one_shot_in = '0;
        req_ch.repeat_mode = '0;
        req_ch.weekday_now = '0;
        req_ch.day_number = '0;
        req_ch.time_valid = 1'b0;
        rsp_ch.ready = 1'b0;
        hold_next = 1'b0;
        cmd_on_bus = '0;
        foreach (slot_shadow[i])
            slot_shadow[i] = '0;

        // directed: time not valid, empty table, never-written slots
        push_cmd(check_cmd(8'hFF, 8'hFF, 3'd7, 32'hFFFF_FFFF, 1'b0));
        push_cmd(check_cmd(8'd0, 8'd0, 3'd0, 32'd0, 1'b1));
        push_cmd(plain_cmd(CMD_GET, 8'd0));
        push_cmd(plain_cmd(CMD_TOGGLE, 8'd3));
        push_cmd(plain_cmd(CMD_DELETE, 8'd5));
        // clamping, zero mask, then the same values spelled differently
        push_cmd(set_cmd(8'd0, 8'h80, 8'hFF, 8'hFF, 8'h80, 8'h01));
        push_cmd(set_cmd(8'd0, 8'hFF, 8'd200, 8'd60, 8'h00, 8'hFE));
        push_cmd(plain_cmd(CMD_GET, 8'd0));
        // day zero never fires a fresh slot; day one fires and clears one-shot
        push_cmd(check_cmd(8'd23, 8'd59, 3'd6, 32'd0, 1'b1));
        push_cmd(check_cmd(8'd23, 8'd59, 3'd6, 32'd1, 1'b1));
        push_cmd(plain_cmd(CMD_GET, 8'd0));
        // weekday seven, a fire, then the same day again
        push_cmd(set_cmd(8'd15, 8'd1, 8'd0, 8'd0, 8'h7F, 8'd0));
        push_cmd(check_cmd(8'd0, 8'd0, 3'd7, 32'd5, 1'b1));
        push_cmd(check_cmd(8'd0, 8'd0, 3'd0, 32'd5, 1'b1));
        push_cmd(check_cmd(8'd0, 8'd0, 3'd0, 32'd5, 1'b1));
        // every add mode
        push_cmd(add_cmd(8'd7, 8'd30, MODE_DAILY));
        push_cmd(add_cmd(8'd255, 8'd255, MODE_WORK));
        push_cmd(add_cmd(8'd12, 8'd0, MODE_WEEKEND));
        push_cmd(add_cmd(8'd6, 8'd45, MODE_ONCE));
        // slot index out of range
        push_cmd(plain_cmd(CMD_SET, 8'd16));
        push_cmd(plain_cmd(CMD_GET, 8'd255));
        push_cmd(plain_cmd(CMD_TOGGLE, 8'd128));
        push_cmd(plain_cmd(CMD_DELETE, 8'd200));
        // toggle off and on, delete, spare codes, last day of the counter
        push_cmd(plain_cmd(CMD_TOGGLE, 8'd15));
        push_cmd(plain_cmd(CMD_TOGGLE, 8'd15));
        push_cmd(plain_cmd(CMD_DELETE, 8'd15));
        w = rand_word();
        w.cmd = CMD_UNUSED_A;
        push_cmd(w);
        w = rand_word();
        w.cmd = CMD_UNUSED_B;
        push_cmd(w);
        push_cmd(check_cmd(8'd7, 8'd30, 3'd3, 32'hFFFF_FFFF, 1'b1));

        // random episodes; the first one starts only once the pipe is empty
        hold_next = 1'b1;
        cur_day = 32'd1;
        while (cmd_backlog.size() < N_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       cur_day = 32'd0;
                1:       cur_day = 32'hFFFF_FFFE;
                2:       cur_day = $urandom();
                default: ;
            endcase
            if ($urandom_range(0, 24) == 0)
                hold_next = 1'b1;
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                // a few table writes, then a run of check commands
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 7))
                        0, 1, 2: push_cmd(tame_word(CMD_SET, cur_day));
                        3, 4:    push_cmd(tame_word(CMD_ADD, cur_day));
                        5:       push_cmd(tame_word(CMD_TOGGLE, cur_day));
                        6:       push_cmd(tame_word(CMD_DELETE, cur_day));
                        default: push_cmd(tame_word(CMD_GET, cur_day));
                    endcase
                end
                repeat ($urandom_range(3, 12))
                begin
                    if ($urandom_range(0, 5) == 0)
                        cur_day = cur_day + 32'd1;
                    push_cmd(tame_word(CMD_CHECK, cur_day));
                end
            end
            else if (kind == 6)
            begin
                // fill the table so that add wraps to slot 0
                hold_next = 1'b1;
                repeat (SLOTS + $urandom_range(1, 3))
                    push_cmd(tame_word(CMD_ADD, cur_day));
                repeat ($urandom_range(2, 6))
                    push_cmd(tame_word(CMD_CHECK, cur_day));
            end
            else if (kind == 7)
            begin
                repeat ($urandom_range(5, 10))
                    push_cmd(rand_word());
            end
            else
            begin
                repeat ($urandom_range(4, 10))
                    push_cmd(tame_word(3'($urandom_range(0, 7)), cur_day));
            end
        end
        total_words = cmd_backlog.size();

        // single reset at the start, released away from the rising edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (words_taken == total_words);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0)
            $display("weekly_alarm_slot_table test passed");
        else
            $display("weekly_alarm_slot_table test failed");
        $finish;
    end

endmodule
